@@ sv/tsfd_pkg.sv @@
// Shared constants, types and helpers for the tempo-synced feedback delay.
// Used by the channel datapath, the top level and the port checker.
// No dependencies.
package tsfd_pkg;

    // Delay store geometry
    localparam int DELAY_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);

    // Sample format
    localparam int SAMPLE_W = 24;
    localparam int WIDE_W   = 48;

    // Register field widths
    localparam int EIGHTHS_W = 4;
    localparam int SAMPLES_W = 17;
    localparam int GAIN_W    = 15;
    localparam int MIX_W     = 17;
    localparam int DPROD_W   = EIGHTHS_W + SAMPLES_W;

    // Arithmetic widths
    localparam int DRY_W     = MIX_W + 1;
    localparam int FB_PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int MIX_PROD_W = SAMPLE_W + DRY_W;
    localparam int MIX_SUM_W  = MIX_PROD_W + 1;
    localparam int GAIN_FRAC  = 15;
    localparam int MIX_FRAC   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_EIGHTHS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EIGHTH_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd3;

    // Reset values
    localparam logic [EIGHTHS_W-1:0] EIGHTHS_RST = '0;
    localparam logic [SAMPLES_W-1:0] SAMPLES_RST = 17'd12000;
    localparam logic [GAIN_W-1:0]    GAIN_RST    = 15'd16384;
    localparam logic [MIX_W-1:0]     MIX_RST     = 17'd32768;
    localparam logic [MIX_W:0]       MIX_UNITY   = 18'd65536;

    // Per-item control shared by both channel datapaths
    typedef struct packed {
        logic              accept;      // input beat taken this cycle
        logic [ADDR_W-1:0] rd_addr;     // read address of the incoming beat
        logic              s1_adv;      // read stage moves into the product stage
        logic              s1_zero;     // read-stage entry never written since reset
        logic              s1_fwd;      // read stage uses the forwarded value
        logic              fwd_capture; // write-back value goes to the forward register
        logic              wr_en;       // write-back this cycle
        logic [ADDR_W-1:0] wr_addr;     // write-back address
    } chan_ctl_t;

    // Static coefficients
    typedef struct packed {
        logic [GAIN_W-1:0]       feedback_gain;
        logic [MIX_W-1:0]        wet_mix;
        logic signed [DRY_W-1:0] dry_mix;
    } chan_cfg_t;

    // Delay in samples, zero when it is zero or reaches the store depth
    function automatic logic [ADDR_W-1:0] clamp_delay(input logic [DPROD_W-1:0] p);
        logic [ADDR_W-1:0] d;
        begin
            if (p >= DPROD_W'(DELAY_DEPTH))
                d = '0;
            else
                d = p[ADDR_W-1:0];
            return d;
        end
    endfunction

    // Clamp a wide signed value to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] r;
        begin
            hi = (WIDE_W'(1) <<< (SAMPLE_W - 1)) - WIDE_W'(1);
            lo = -hi - WIDE_W'(1);
            if (v > hi)
                r = hi[SAMPLE_W-1:0];
            else if (v < lo)
                r = lo[SAMPLE_W-1:0];
            else
                r = v[SAMPLE_W-1:0];
            return r;
        end
    endfunction

endpackage

@@ sv/tsfd_channel.sv @@
// One channel of the delay: delay store, forwarding register, products and write-back.
// Depends on tsfd_pkg; control comes from the top level, which owns positions and valids.
module tsfd_channel (
    input  logic                                clk,
    input  tsfd_pkg::chan_ctl_t                 ctl,
    input  tsfd_pkg::chan_cfg_t                 cfg,
    input  logic signed [tsfd_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [tsfd_pkg::SAMPLE_W-1:0] sample_out
);

    // Delay store, one read port registered, one write port
    logic [tsfd_pkg::SAMPLE_W-1:0] store_mem [tsfd_pkg::DELAY_DEPTH];
    logic [tsfd_pkg::SAMPLE_W-1:0] mem_q_reg;

    logic signed [tsfd_pkg::SAMPLE_W-1:0]   fwd_data_reg;
    logic signed [tsfd_pkg::SAMPLE_W-1:0]   s1_in_reg;
    logic signed [tsfd_pkg::SAMPLE_W-1:0]   s2_in_reg;
    logic signed [tsfd_pkg::FB_PROD_W-1:0]  fb_prod_reg;
    logic signed [tsfd_pkg::MIX_PROD_W-1:0] wet_prod_reg;
    logic signed [tsfd_pkg::MIX_PROD_W-1:0] dry_prod_reg;

    logic signed [tsfd_pkg::SAMPLE_W-1:0]   delayed;
    logic signed [tsfd_pkg::FB_PROD_W-1:0]  fb_prod_next;
    logic signed [tsfd_pkg::MIX_PROD_W-1:0] wet_prod_next;
    logic signed [tsfd_pkg::MIX_PROD_W-1:0] dry_prod_next;

    logic signed [tsfd_pkg::FB_PROD_W-1:0]  fb_biased;
    logic signed [tsfd_pkg::SAMPLE_W:0]     fb_rnd;
    logic signed [tsfd_pkg::SAMPLE_W+1:0]   fb_sum;
    logic signed [tsfd_pkg::MIX_SUM_W-1:0]  mix_sum;
    logic signed [tsfd_pkg::MIX_SUM_W-1:0]  mix_biased;
    logic signed [tsfd_pkg::MIX_SUM_W-tsfd_pkg::MIX_FRAC-1:0] mix_rnd;
    logic signed [tsfd_pkg::SAMPLE_W-1:0]   wdata;

    // Store write-back and read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[ctl.wr_addr] <= wdata;
        end
        if (ctl.accept)
        begin
            mem_q_reg <= store_mem[ctl.rd_addr];
        end
    end

    // Forwarded write-back value for the beat in the read stage
    always_ff @(posedge clk)
    begin
        if (ctl.fwd_capture)
        begin
            fwd_data_reg <= wdata;
        end
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            s1_in_reg <= sample_in;
        end
    end

    // Delayed sample: forwarded, never written, or from the store
    always_comb
    begin
        if (ctl.s1_fwd)
            delayed = fwd_data_reg;
        else if (ctl.s1_zero)
            delayed = '0;
        else
            delayed = $signed(mem_q_reg);
    end

    // Products
    always_comb
    begin
        fb_prod_next  = delayed * $signed({1'b0, cfg.feedback_gain});
        wet_prod_next = delayed * $signed({1'b0, cfg.wet_mix});
        dry_prod_next = s1_in_reg * cfg.dry_mix;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_adv)
        begin
            fb_prod_reg  <= fb_prod_next;
            wet_prod_reg <= wet_prod_next;
            dry_prod_reg <= dry_prod_next;
            s2_in_reg    <= s1_in_reg;
        end
    end

    // Feedback: round half up, add input, saturate
    always_comb
    begin
        fb_biased = fb_prod_reg
                  + tsfd_pkg::FB_PROD_W'(1 <<< (tsfd_pkg::GAIN_FRAC - 1));
        fb_rnd    = fb_biased[tsfd_pkg::FB_PROD_W-1:tsfd_pkg::GAIN_FRAC];
        fb_sum    = {{2{s2_in_reg[tsfd_pkg::SAMPLE_W-1]}}, s2_in_reg}
                  + {fb_rnd[tsfd_pkg::SAMPLE_W], fb_rnd};
        wdata     = tsfd_pkg::sat_sample(
                        {{(tsfd_pkg::WIDE_W-tsfd_pkg::SAMPLE_W-2)
                          {fb_sum[tsfd_pkg::SAMPLE_W+1]}}, fb_sum});
    end

    // Wet/dry blend: round half up, saturate
    always_comb
    begin
        mix_sum    = {wet_prod_reg[tsfd_pkg::MIX_PROD_W-1], wet_prod_reg}
                   + {dry_prod_reg[tsfd_pkg::MIX_PROD_W-1], dry_prod_reg};
        mix_biased = mix_sum
                   + tsfd_pkg::MIX_SUM_W'(1 <<< (tsfd_pkg::MIX_FRAC - 1));
        mix_rnd    = mix_biased[tsfd_pkg::MIX_SUM_W-1:tsfd_pkg::MIX_FRAC];
        sample_out = tsfd_pkg::sat_sample(
                         {{(tsfd_pkg::WIDE_W-tsfd_pkg::MIX_SUM_W+tsfd_pkg::MIX_FRAC)
                           {mix_rnd[tsfd_pkg::MIX_SUM_W-tsfd_pkg::MIX_FRAC-1]}},
                          mix_rnd});
    end

endmodule

@@ sv/tempo_synced_feedback_delay.sv @@
// A result beat passes the read stage, the product stage and the output register before it is offered.
// Throughput: one stereo beat per cycle while the output is not stalled; a beat whose delayed entry
// is written by the beat one stage ahead (a delay of one sample) holds in the read stage until
// that write-back is done and forwarded to it.
// Reset: registers to defaults, write position to zero; store entries never
// written since reset read as zero, tracked by the write position, no clearing pass.
module tempo_synced_feedback_delay (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tsfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tsfd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tsfd_pkg::SAMPLE_W-1:0]   left_in,
    input  logic signed [tsfd_pkg::SAMPLE_W-1:0]   right_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tsfd_pkg::SAMPLE_W-1:0]   left_out,
    output logic signed [tsfd_pkg::SAMPLE_W-1:0]   right_out
);

    // Configuration registers
    logic [tsfd_pkg::EIGHTHS_W-1:0]   delay_eighths_reg;
    logic [tsfd_pkg::SAMPLES_W-1:0]   eighth_samples_reg;
    logic [tsfd_pkg::GAIN_W-1:0]      feedback_gain_reg;
    logic [tsfd_pkg::MIX_W-1:0]       wet_mix_reg;
    logic signed [tsfd_pkg::DRY_W-1:0] dry_mix_reg;
    logic [tsfd_pkg::ADDR_W-1:0]      delay_reg;

    logic                             cfg_we;
    logic [tsfd_pkg::EIGHTHS_W-1:0]   eighths_op;
    logic [tsfd_pkg::SAMPLES_W-1:0]   samples_op;
    logic [tsfd_pkg::DPROD_W-1:0]     delay_prod;

    // Position and pipeline control
    logic [tsfd_pkg::ADDR_W-1:0] wr_pos_reg;
    logic                        wrapped_reg;
    logic [tsfd_pkg::ADDR_W-1:0] rd_next;
    logic                        zero_next;

    logic                        s1_valid_reg;
    logic [tsfd_pkg::ADDR_W-1:0] s1_rd_reg;
    logic [tsfd_pkg::ADDR_W-1:0] s1_wr_reg;
    logic                        s1_zero_reg;
    logic                        fwd_valid_reg;
    logic                        s2_valid_reg;
    logic [tsfd_pkg::ADDR_W-1:0] s2_wr_reg;
    logic                        out_valid_reg;
    logic signed [tsfd_pkg::SAMPLE_W-1:0] left_out_reg;
    logic signed [tsfd_pkg::SAMPLE_W-1:0] right_out_reg;

    logic                        in_accept;
    logic                        s2_adv;
    logic                        s1_adv;
    logic                        s1_conflict;
    logic                        wr_en;
    logic                        fwd_capture;

    tsfd_pkg::chan_ctl_t         ctl;
    tsfd_pkg::chan_cfg_t         coef;
    logic signed [tsfd_pkg::SAMPLE_W-1:0] left_res;
    logic signed [tsfd_pkg::SAMPLE_W-1:0] right_res;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Delay product formed from the register being written and the other one
    always_comb
    begin
        eighths_op = (cfg_index == tsfd_pkg::REG_DELAY_EIGHTHS)
                   ? cfg_data[tsfd_pkg::EIGHTHS_W-1:0] : delay_eighths_reg;
        samples_op = (cfg_index == tsfd_pkg::REG_EIGHTH_SAMPLES)
                   ? cfg_data[tsfd_pkg::SAMPLES_W-1:0] : eighth_samples_reg;
        delay_prod = tsfd_pkg::DPROD_W'(eighths_op) * tsfd_pkg::DPROD_W'(samples_op);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_eighths_reg  <= tsfd_pkg::EIGHTHS_RST;
            eighth_samples_reg <= tsfd_pkg::SAMPLES_RST;
            feedback_gain_reg  <= tsfd_pkg::GAIN_RST;
            wet_mix_reg        <= tsfd_pkg::MIX_RST;
            dry_mix_reg        <= $signed(tsfd_pkg::MIX_UNITY
                                          - {1'b0, tsfd_pkg::MIX_RST});
            delay_reg          <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsfd_pkg::REG_DELAY_EIGHTHS:
                begin
                    delay_eighths_reg <= cfg_data[tsfd_pkg::EIGHTHS_W-1:0];
                    delay_reg         <= tsfd_pkg::clamp_delay(delay_prod);
                end
                tsfd_pkg::REG_EIGHTH_SAMPLES:
                begin
                    eighth_samples_reg <= cfg_data[tsfd_pkg::SAMPLES_W-1:0];
                    delay_reg          <= tsfd_pkg::clamp_delay(delay_prod);
                end
                tsfd_pkg::REG_FEEDBACK_GAIN:
                begin
                    feedback_gain_reg <= cfg_data[tsfd_pkg::GAIN_W-1:0];
                end
                tsfd_pkg::REG_WET_MIX:
                begin
                    wet_mix_reg <= cfg_data[tsfd_pkg::MIX_W-1:0];
                    dry_mix_reg <= $signed(tsfd_pkg::MIX_UNITY
                                           - {1'b0, cfg_data[tsfd_pkg::MIX_W-1:0]});
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read address and never-written test for the incoming beat
    always_comb
    begin
        rd_next   = wr_pos_reg - delay_reg;
        zero_next = !(wrapped_reg || (rd_next < wr_pos_reg));
    end

    // Stage handshakes; the read stage holds while the stage ahead still owes
    // a write to the entry it has read
    always_comb
    begin
        s2_adv      = !out_valid_reg || out_ready;
        s1_conflict = s2_valid_reg && (s2_wr_reg == s1_rd_reg);
        s1_adv      = s1_valid_reg && (!s2_valid_reg || s2_adv) && !s1_conflict;
        in_ready    = !s1_valid_reg || s1_adv;
        in_accept   = in_valid && in_ready;
        wr_en       = s2_valid_reg && s2_adv;
        if (in_accept)
            fwd_capture = wr_en && (s2_wr_reg == rd_next);
        else
            fwd_capture = wr_en && (s2_wr_reg == s1_rd_reg);
    end

    // Write position and fill tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg  <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            wr_pos_reg <= wr_pos_reg + tsfd_pkg::ADDR_W'(1);
            if (&wr_pos_reg)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // Pipeline valids and addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_rd_reg     <= '0;
            s1_wr_reg     <= '0;
            s1_zero_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_wr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg  <= 1'b1;
                s1_rd_reg     <= rd_next;
                s1_wr_reg     <= wr_pos_reg;
                s1_zero_reg   <= zero_next;
                fwd_valid_reg <= fwd_capture;
            end
            else
            begin
                if (s1_adv)
                begin
                    s1_valid_reg <= 1'b0;
                end
                if (fwd_capture)
                begin
                    fwd_valid_reg <= 1'b1;
                end
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                s2_wr_reg    <= s1_wr_reg;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_out_reg  <= left_res;
            right_out_reg <= right_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // Shared channel control and coefficients
    always_comb
    begin
        ctl.accept      = in_accept;
        ctl.rd_addr     = rd_next;
        ctl.s1_adv      = s1_adv;
        ctl.s1_zero     = s1_zero_reg;
        ctl.s1_fwd      = fwd_valid_reg;
        ctl.fwd_capture = fwd_capture;
        ctl.wr_en       = wr_en;
        ctl.wr_addr     = s2_wr_reg;

        coef.feedback_gain = feedback_gain_reg;
        coef.wet_mix       = wet_mix_reg;
        coef.dry_mix       = dry_mix_reg;
    end

    tsfd_channel u_left (
        .clk        (clk),
        .ctl        (ctl),
        .cfg        (coef),
        .sample_in  (left_in),
        .sample_out (left_res)
    );

    tsfd_channel u_right (
        .clk        (clk),
        .ctl        (ctl),
        .cfg        (coef),
        .sample_in  (right_in),
        .sample_out (right_res)
    );

endmodule

@@ sv/tsfd_checker.sv @@
// Port-level checks for the tempo-synced feedback delay, bound to the top level.
// Depends on tsfd_pkg for widths; sees only the top-level ports.
module tsfd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [tsfd_pkg::SAMPLE_W-1:0] left_out,
    input logic signed [tsfd_pkg::SAMPLE_W-1:0] right_out
);

    // Beats taken but not yet delivered
    logic [2:0] pend_reg;
    logic       in_beat;
    logic       out_beat;
    logic       out_stall;

    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid && out_ready;
    assign out_stall = out_valid && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 3'(in_beat) - 3'(out_beat);
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("result beat changed while stalled");

    // No result without a beat taken before it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 3'd0))
        else $error("result beat with nothing outstanding");

    // At most three beats in flight: read stage, product stage, output
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("more beats in flight than stages");

    // Without output back-pressure a blocked input side is ready again in the following cycle
    a_ready_recover: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready && !out_stall) |=> (in_ready || out_stall))
        else $error("input blocked without output back-pressure");

endmodule

bind tempo_synced_feedback_delay tsfd_checker u_tsfd_checker (.*);
